@@ src/ppft_pkg.sv @@
// Shared types and constants for the planar pose frame transform.
// Holds the transaction structs, the rotation pipeline constants and the arctangent table.
// No dependencies.
package ppft_pkg;

    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned POS_W        = 24;
    localparam int unsigned ANG_W        = 16;
    localparam int unsigned CS_W         = 32;
    localparam int unsigned PROD_W       = POS_W + CS_W;
    localparam int unsigned SUM_W        = PROD_W + 2;
    localparam int unsigned FRAC_SHIFT   = 30;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN  = 32'sd652032874;
    localparam logic [ANG_W-1:0]       QUARTER_TURN = 16'd16384;
    localparam logic [ANG_W-1:0]       EIGHTH_TURN  = 16'd8192;
    localparam logic signed [POS_W-1:0] POS_MAX     = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN     = 24'sh800000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Arctangent of 2^-i, 2^32 being a full turn.
    localparam logic signed [CS_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef struct packed {
        logic signed [POS_W-1:0] rel_x;
        logic signed [POS_W-1:0] rel_y;
        logic [ANG_W-1:0]        rel_heading;
        logic [ANG_W-1:0]        rel_heading_unc;
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic [ANG_W-1:0]        ref_heading;
        logic [ANG_W-1:0]        ref_heading_unc;
        logic [31:0]             stamp;
        logic [7:0]              object_id;
    } t_pose_in;

    typedef struct packed {
        logic signed [POS_W-1:0] field_x;
        logic signed [POS_W-1:0] field_y;
        logic [ANG_W-1:0]        field_heading;
        logic [ANG_W-1:0]        field_heading_unc;
        logic [31:0]             out_stamp;
        logic [7:0]              out_id;
    } t_pose_out;

    // Data that rides along the rotation pipeline untouched.
    typedef struct packed {
        logic signed [POS_W-1:0] rel_x;
        logic signed [POS_W-1:0] rel_y;
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic [ANG_W-1:0]        heading;
        logic [ANG_W-1:0]        heading_unc;
        logic [31:0]             stamp;
        logic [7:0]              object_id;
        logic [1:0]              quad;
    } t_carry;

endpackage

@@ src/planar_pose_frame_transform.sv @@
// Top level of the planar pose frame transform: a fully pipelined SE(2) pose composition.
// Uses ppft_pkg for the transaction structs, the arctangent table and the constants.
//
// Usage:
//   A transaction enters when start is high while busy is low. busy is always low, so a
//   new pose pair may be offered in every clock cycle.
//   Each transaction yields exactly one result on o_result, marked by o_done for one cycle.
//   Results leave in arrival order.
//   Throughput is one transaction per cycle: the 24 rotation steps each own a pipeline
//   stage, followed by one multiply stage, one add stage and one saturate stage.
//   The receiver has no way to stall the block; every result must be taken when o_done
//   is high.
//   Synchronous active-low reset clears all valid bits, so no result appears after
//   reset until a new transaction is accepted. Data registers are not reset.
//   The rotation angle is the robot heading minus a quarter turn; the nearest quarter is
//   split off and applied exactly after the iterative rotation.
module planar_pose_frame_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ppft_pkg::t_pose_in  i_item,
    output logic                o_done,
    output ppft_pkg::t_pose_out o_result
);

    localparam int unsigned NS = ppft_pkg::CORDIC_STEPS;
    localparam int unsigned CW = ppft_pkg::CS_W;

    // Front end: rotation angle, quadrant and remainder.
    logic [ppft_pkg::ANG_W-1:0] theta;
    logic [ppft_pkg::ANG_W-1:0] quad_sum;
    logic [1:0]                 quad;
    logic [ppft_pkg::ANG_W-1:0] rem16;
    logic [ppft_pkg::ANG_W:0]   unc_sum;
    ppft_pkg::t_carry           carry_in;

    always_comb begin
        theta    = i_item.ref_heading - ppft_pkg::QUARTER_TURN;
        quad_sum = theta + ppft_pkg::EIGHTH_TURN;
        quad     = quad_sum[ppft_pkg::ANG_W-1 -: 2];
        rem16    = theta - {quad, {(ppft_pkg::ANG_W-2){1'b0}}};
        unc_sum  = {1'b0, i_item.rel_heading_unc} + {1'b0, i_item.ref_heading_unc};
        carry_in.rel_x       = i_item.rel_x;
        carry_in.rel_y       = i_item.rel_y;
        carry_in.ref_x       = i_item.ref_x;
        carry_in.ref_y       = i_item.ref_y;
        carry_in.heading     = theta + i_item.rel_heading;
        carry_in.heading_unc = unc_sum[ppft_pkg::ANG_W] ? {ppft_pkg::ANG_W{1'b1}}
                                                         : unc_sum[ppft_pkg::ANG_W-1:0];
        carry_in.stamp       = i_item.stamp;
        carry_in.object_id   = i_item.object_id;
        carry_in.quad        = quad;
    end

    // Rotation pipeline: stage k holds the vector after k steps.
    logic                   r_cv [NS+1];
    logic signed [CW-1:0]   r_cx [NS+1];
    logic signed [CW-1:0]   r_cy [NS+1];
    logic signed [CW-1:0]   r_cz [NS+1];
    ppft_pkg::t_carry       r_cd [NS+1];
    logic signed [CW-1:0]   n_cx [NS];
    logic signed [CW-1:0]   n_cy [NS];
    logic signed [CW-1:0]   n_cz [NS];

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (!r_cz[i][CW-1]) begin
                n_cx[i] = r_cx[i] - (r_cy[i] >>> i);
                n_cy[i] = r_cy[i] + (r_cx[i] >>> i);
                n_cz[i] = r_cz[i] - ppft_pkg::ATAN_TAB[i];
            end else begin
                n_cx[i] = r_cx[i] + (r_cy[i] >>> i);
                n_cy[i] = r_cy[i] - (r_cx[i] >>> i);
                n_cz[i] = r_cz[i] + ppft_pkg::ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0] <= ppft_pkg::CORDIC_GAIN;
        r_cy[0] <= '0;
        r_cz[0] <= {rem16, {(CW-ppft_pkg::ANG_W){1'b0}}};
        r_cd[0] <= carry_in;
        for (int i = 0; i < NS; i++) begin
            r_cx[i+1] <= n_cx[i];
            r_cy[i+1] <= n_cy[i];
            r_cz[i+1] <= n_cz[i];
            r_cd[i+1] <= r_cd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_cv[i] <= 1'b0;
            end
        end else begin
            r_cv[0] <= start;
            for (int i = 0; i < NS; i++) begin
                r_cv[i+1] <= r_cv[i];
            end
        end
    end

    // Quadrant correction and the four products.
    logic signed [CW-1:0] cos_q;
    logic signed [CW-1:0] sin_q;

    always_comb begin
        case (r_cd[NS].quad)
            ppft_pkg::QUAD_1: begin
                cos_q = -r_cy[NS];
                sin_q = r_cx[NS];
            end
            ppft_pkg::QUAD_2: begin
                cos_q = -r_cx[NS];
                sin_q = -r_cy[NS];
            end
            ppft_pkg::QUAD_3: begin
                cos_q = r_cy[NS];
                sin_q = -r_cx[NS];
            end
            default: begin
                cos_q = r_cx[NS];
                sin_q = r_cy[NS];
            end
        endcase
    end

    logic                                 r_mv;
    ppft_pkg::t_carry                     r_md;
    logic signed [ppft_pkg::PROD_W-1:0]   r_pxc;
    logic signed [ppft_pkg::PROD_W-1:0]   r_pys;
    logic signed [ppft_pkg::PROD_W-1:0]   r_pxs;
    logic signed [ppft_pkg::PROD_W-1:0]   r_pyc;

    always_ff @(posedge i_clk) begin
        r_md  <= r_cd[NS];
        r_pxc <= ppft_pkg::PROD_W'(r_cd[NS].rel_x) * ppft_pkg::PROD_W'(cos_q);
        r_pys <= ppft_pkg::PROD_W'(r_cd[NS].rel_y) * ppft_pkg::PROD_W'(sin_q);
        r_pxs <= ppft_pkg::PROD_W'(r_cd[NS].rel_x) * ppft_pkg::PROD_W'(sin_q);
        r_pyc <= ppft_pkg::PROD_W'(r_cd[NS].rel_y) * ppft_pkg::PROD_W'(cos_q);
    end

    // Combine products with the rounding offset of one half.
    localparam logic signed [ppft_pkg::SUM_W-1:0] ROUND_HALF =
        ppft_pkg::SUM_W'(1) <<< (ppft_pkg::FRAC_SHIFT - 1);

    logic                                r_av;
    ppft_pkg::t_carry                    r_ad;
    logic signed [ppft_pkg::SUM_W-1:0]   r_sx;
    logic signed [ppft_pkg::SUM_W-1:0]   r_sy;

    always_ff @(posedge i_clk) begin
        r_ad <= r_md;
        r_sx <= ppft_pkg::SUM_W'(r_pxc) - ppft_pkg::SUM_W'(r_pys) + ROUND_HALF;
        r_sy <= ppft_pkg::SUM_W'(r_pxs) + ppft_pkg::SUM_W'(r_pyc) + ROUND_HALF;
    end

    // Scale down, add the robot position and clamp to the coordinate range.
    localparam int unsigned SH_W  = ppft_pkg::SUM_W - ppft_pkg::FRAC_SHIFT;
    localparam int unsigned ADD_W = SH_W + 1;

    logic signed [SH_W-1:0]  sx_sh;
    logic signed [SH_W-1:0]  sy_sh;
    logic signed [ADD_W-1:0] fx_full;
    logic signed [ADD_W-1:0] fy_full;
    logic signed [ppft_pkg::POS_W-1:0] fx_sat;
    logic signed [ppft_pkg::POS_W-1:0] fy_sat;

    always_comb begin
        sx_sh   = r_sx[ppft_pkg::SUM_W-1:ppft_pkg::FRAC_SHIFT];
        sy_sh   = r_sy[ppft_pkg::SUM_W-1:ppft_pkg::FRAC_SHIFT];
        fx_full = ADD_W'(sx_sh) + ADD_W'(r_ad.ref_x);
        fy_full = ADD_W'(sy_sh) + ADD_W'(r_ad.ref_y);
        if (fx_full > ADD_W'(ppft_pkg::POS_MAX)) begin
            fx_sat = ppft_pkg::POS_MAX;
        end else if (fx_full < ADD_W'(ppft_pkg::POS_MIN)) begin
            fx_sat = ppft_pkg::POS_MIN;
        end else begin
            fx_sat = fx_full[ppft_pkg::POS_W-1:0];
        end
        if (fy_full > ADD_W'(ppft_pkg::POS_MAX)) begin
            fy_sat = ppft_pkg::POS_MAX;
        end else if (fy_full < ADD_W'(ppft_pkg::POS_MIN)) begin
            fy_sat = ppft_pkg::POS_MIN;
        end else begin
            fy_sat = fy_full[ppft_pkg::POS_W-1:0];
        end
    end

    logic                r_ov;
    ppft_pkg::t_pose_out r_out;

    always_ff @(posedge i_clk) begin
        r_out.field_x           <= fx_sat;
        r_out.field_y           <= fy_sat;
        r_out.field_heading     <= r_ad.heading;
        r_out.field_heading_unc <= r_ad.heading_unc;
        r_out.out_stamp         <= r_ad.stamp;
        r_out.out_id            <= r_ad.object_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_mv <= r_cv[NS];
            r_av <= r_mv;
            r_ov <= r_av;
        end
    end

    assign busy     = 1'b0;
    assign o_done   = r_ov;
    assign o_result = r_out;

endmodule

@@ test/pose_composition_checker.sv @@
`timescale 1ns / 100ps
// Checker for the planar pose frame transform: predicts each result and compares it.
// Watches the command and result channels of the block; uses ppft_pkg for the structs.
module pose_composition_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  ppft_pkg::t_pose_in  i_item,
    input  logic                i_done,
    input  ppft_pkg::t_pose_out i_result,
    output int                  o_mismatches,
    output int                  o_pending
);

    ppft_pkg::t_pose_out expected_poses[$];
    int                  mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Object pose in the field frame: rotate by robot heading minus a quarter turn,
    // then translate by the robot position.
    function automatic ppft_pkg::t_pose_out compose_pose(input ppft_pkg::t_pose_in p);
        logic [ppft_pkg::ANG_W-1:0] theta;
        logic [31:0]                wide_ang;
        logic [31:0]                rounded;
        logic [31:0]                remainder;
        logic [1:0]                 quad;
        longint                     x, y, z, dx, dy, c, s, fx, fy;
        logic [ppft_pkg::ANG_W:0]   unc_sum;
        ppft_pkg::t_pose_out        r;
        theta     = p.ref_heading - ppft_pkg::QUARTER_TURN;
        wide_ang  = {theta, 16'h0000};
        rounded   = wide_ang + 32'h2000_0000;
        quad      = rounded[31:30];
        remainder = wide_ang - {quad, 30'b0};
        z = longint'($signed(remainder));
        x = longint'(ppft_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < ppft_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ppft_pkg::ATAN_TAB[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ppft_pkg::ATAN_TAB[i]);
            end
        end
        case (quad)
            ppft_pkg::QUAD_1: begin c = -y; s = x; end
            ppft_pkg::QUAD_2: begin c = -x; s = -y; end
            ppft_pkg::QUAD_3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
        fx = ((longint'(p.rel_x) * c - longint'(p.rel_y) * s + (longint'(1) << 29)) >>> 30)
             + longint'(p.ref_x);
        fy = ((longint'(p.rel_x) * s + longint'(p.rel_y) * c + (longint'(1) << 29)) >>> 30)
             + longint'(p.ref_y);
        if (fx > longint'(ppft_pkg::POS_MAX)) fx = longint'(ppft_pkg::POS_MAX);
        if (fx < longint'(ppft_pkg::POS_MIN)) fx = longint'(ppft_pkg::POS_MIN);
        if (fy > longint'(ppft_pkg::POS_MAX)) fy = longint'(ppft_pkg::POS_MAX);
        if (fy < longint'(ppft_pkg::POS_MIN)) fy = longint'(ppft_pkg::POS_MIN);
        unc_sum = {1'b0, p.rel_heading_unc} + {1'b0, p.ref_heading_unc};
        r.field_x           = fx[ppft_pkg::POS_W-1:0];
        r.field_y           = fy[ppft_pkg::POS_W-1:0];
        r.field_heading     = theta + p.rel_heading;
        r.field_heading_unc = unc_sum[ppft_pkg::ANG_W] ? '1
                                                       : unc_sum[ppft_pkg::ANG_W-1:0];
        r.out_stamp         = p.stamp;
        r.out_id            = p.object_id;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        ppft_pkg::t_pose_out want;
        if (i_rst_n) begin
            if (i_done) begin
                if (expected_poses.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("field_x", want.field_x, i_result.field_x);
                    check_field("field_y", want.field_y, i_result.field_y);
                    check_field("field_heading", want.field_heading, i_result.field_heading);
                    check_field("field_heading_unc", want.field_heading_unc,
                                i_result.field_heading_unc);
                    check_field("out_stamp", want.out_stamp, i_result.out_stamp);
                    check_field("out_id", want.out_id, i_result.out_id);
                end
            end
            if (i_start && !i_busy) begin
                expected_poses.push_back(compose_pose(i_item));
            end
        end
        o_pending = expected_poses.size();
    end

endmodule

@@ test/tb_planar_pose_frame_transform.sv @@
`timescale 1ns / 100ps
// Testbench top for the planar pose frame transform: directed and random pose pairs in bursts.
// Depends on ppft_pkg, planar_pose_frame_transform and pose_composition_checker.
module tb_planar_pose_frame_transform;

    localparam int PIPE_LATENCY  = 27;
    localparam int RANDOM_ITEMS  = 500;
    localparam int LIMIT_CYCLES  = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    ppft_pkg::t_pose_in  i_item;
    logic                o_done;
    ppft_pkg::t_pose_out o_result;
    int                  mismatches;
    int                  pending;
    int                  cycle_count = 0;

    planar_pose_frame_transform u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    pose_composition_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [ppft_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return ppft_pkg::POS_MAX;
            1: return ppft_pkg::POS_MIN;
            2: return ppft_pkg::POS_W'($urandom_range(0, 1023)) - ppft_pkg::POS_W'(512);
            3: return ppft_pkg::POS_W'($urandom_range(0, 65535)) - ppft_pkg::POS_W'(32768);
            default: return ppft_pkg::POS_W'($urandom());
        endcase
    endfunction

    // Bias toward the quarter and eighth points, where the quadrant split changes.
    function automatic logic [ppft_pkg::ANG_W-1:0] rand_angle();
        if ($urandom_range(0, 3) == 0)
            return ppft_pkg::ANG_W'($urandom_range(0, 7)) * ppft_pkg::EIGHTH_TURN
                   + ppft_pkg::ANG_W'($urandom_range(0, 2)) - ppft_pkg::ANG_W'(1);
        return ppft_pkg::ANG_W'($urandom());
    endfunction

    function automatic logic [ppft_pkg::ANG_W-1:0] rand_unc();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return ppft_pkg::ANG_W'($urandom_range(32768, 65535));
            2: return ppft_pkg::ANG_W'($urandom_range(0, 15));
            default: return ppft_pkg::ANG_W'($urandom());
        endcase
    endfunction

    function automatic ppft_pkg::t_pose_in random_pose_pair();
        ppft_pkg::t_pose_in p;
        p.rel_x           = rand_pos();
        p.rel_y           = rand_pos();
        p.rel_heading     = rand_angle();
        p.rel_heading_unc = rand_unc();
        p.ref_x           = rand_pos();
        p.ref_y           = rand_pos();
        p.ref_heading     = rand_angle();
        p.ref_heading_unc = rand_unc();
        p.stamp           = $urandom();
        p.object_id       = 8'($urandom());
        return p;
    endfunction

    function automatic ppft_pkg::t_pose_in make_pose_pair(
        input logic [ppft_pkg::POS_W-1:0] rx, ry, input logic [ppft_pkg::ANG_W-1:0] rh, ru,
        input logic [ppft_pkg::POS_W-1:0] gx, gy, input logic [ppft_pkg::ANG_W-1:0] gh, gu,
        input logic [31:0] stamp, input logic [7:0] id);
        ppft_pkg::t_pose_in p;
        p.rel_x           = rx;
        p.rel_y           = ry;
        p.rel_heading     = rh;
        p.rel_heading_unc = ru;
        p.ref_x           = gx;
        p.ref_y           = gy;
        p.ref_heading     = gh;
        p.ref_heading_unc = gu;
        p.stamp           = stamp;
        p.object_id       = id;
        return p;
    endfunction

    // Offers one transaction at the falling edge and holds it until it is taken.
    task automatic send_pose_pair(input ppft_pkg::t_pose_in p);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
    endtask

    // Start stays low for the given number of cycles; the payload carries noise meanwhile.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= random_pose_pair();
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        ppft_pkg::t_pose_in directed_pairs[$];
        int                 burst_left;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        hold_off(3);

        // Identity rotation, saturation both ways, every quadrant, both boundaries of quadrant 0,
        // heading wrap and uncertainty overflow.
        directed_pairs.push_back(make_pose_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MAX, ppft_pkg::POS_MAX, 0, '1,
                                                ppft_pkg::POS_MAX, ppft_pkg::POS_MAX,
                                                ppft_pkg::QUARTER_TURN, '1, '1, '1));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MIN, ppft_pkg::POS_MIN, 0, 1,
                                                ppft_pkg::POS_MIN, ppft_pkg::POS_MIN,
                                                ppft_pkg::QUARTER_TURN, '1, 0, 0));
        directed_pairs.push_back(make_pose_pair(256, 512, 100, 10, 0, 0, 0, 20, 1, 1));
        directed_pairs.push_back(make_pose_pair(256, 512, 100, 10, 0, 0, 16'd32768, 20, 2, 2));
        directed_pairs.push_back(make_pose_pair(256, 512, 100, 10, 0, 0, 16'd49152, 20, 3, 3));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MAX, ppft_pkg::POS_MIN, 0, 32768,
                                                0, 0,
                                                ppft_pkg::QUARTER_TURN + ppft_pkg::EIGHTH_TURN,
                                                32767, 4, 4));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MAX, ppft_pkg::POS_MIN, 0, 32768,
                                                0, 0,
                                                ppft_pkg::QUARTER_TURN + ppft_pkg::EIGHTH_TURN
                                                - 1, 32768, 5, 5));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MIN, ppft_pkg::POS_MAX, 0, 0,
                                                0, 0,
                                                ppft_pkg::QUARTER_TURN - ppft_pkg::EIGHTH_TURN,
                                                0, 6, 6));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MIN, ppft_pkg::POS_MAX, 0, 0,
                                                0, 0,
                                                ppft_pkg::QUARTER_TURN - ppft_pkg::EIGHTH_TURN
                                                - 1, 0, 7, 7));
        directed_pairs.push_back(make_pose_pair(1000, -1000, '1, 5, 100, -100, '1, 7, 8, 8));
        directed_pairs.push_back(make_pose_pair(-1, -1, 16'h8000, 0, 0, 0, 12345, 0, 9, 9));
        directed_pairs.push_back(make_pose_pair(1, 0, 0, 0, 0, 0,
                                                ppft_pkg::QUARTER_TURN + ppft_pkg::EIGHTH_TURN,
                                                0, 10, 10));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MAX, ppft_pkg::POS_MAX, 0, 0,
                                                ppft_pkg::POS_MAX, ppft_pkg::POS_MAX,
                                                ppft_pkg::QUARTER_TURN + ppft_pkg::EIGHTH_TURN,
                                                0, 11, 11));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MIN, ppft_pkg::POS_MAX, 0, 0,
                                                ppft_pkg::POS_MAX, ppft_pkg::POS_MIN,
                                                16'd49152, 0, 12, 12));
        directed_pairs.push_back(make_pose_pair(ppft_pkg::POS_MAX, ppft_pkg::POS_MAX, 0, 0,
                                                ppft_pkg::POS_MIN, ppft_pkg::POS_MIN,
                                                16'd32768, 0, 13, 13));
        directed_pairs.push_back(make_pose_pair(0, 0, 0, 0,
                                                ppft_pkg::POS_MIN, ppft_pkg::POS_MAX, 0, 0,
                                                32'h5A5A_A5A5, 8'hA5));
        foreach (directed_pairs[k]) send_pose_pair(directed_pairs[k]);
        hold_off(2);
        send_pose_pair(directed_pairs[1]);
        hold_off(5);

        // The opening stretch runs back to back; after that, bursts with random gaps.
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_pose_pair(random_pose_pair());
            if (n >= 80) begin
                burst_left--;
                if (burst_left == 0) begin
                    hold_off(($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
